>>> design/clrle_pkg.sv
// Shared types, constants and helpers for the code-length run-length encoder.
package clrle_pkg;

  localparam int MAX_LENGTHS = 320;
  localparam int ITEM_W      = $clog2(MAX_LENGTHS);
  localparam int NUM_SYMS    = 19;
  localparam int SYM_W       = 5;
  localparam int REP_W       = 8;
  localparam int CNT_W       = 10;
  localparam int MAX_RECS    = 3;
  localparam int NREC_W      = 2;
  localparam int QUEUE_DEPTH = 5;
  localparam int QCNT_W      = 3;
  localparam int QIDX_W      = 3;

  localparam int ZERO_CAP      = 138;
  localparam int REP_CAP       = 6;
  localparam int MIN_RUN       = 3;
  localparam int ZERO_LONG_MIN = 11;
  localparam int COUNT_MAX     = 1023;

  localparam logic [SYM_W-1:0] SYM_REP        = 5'd16;
  localparam logic [SYM_W-1:0] SYM_ZERO_SHORT = 5'd17;
  localparam logic [SYM_W-1:0] SYM_ZERO_LONG  = 5'd18;

  typedef struct packed {
    logic             eob;
    logic             last_item;
    logic [CNT_W-1:0] cnt;
    logic [REP_W-1:0] rep;
    logic [SYM_W-1:0] sym;
  } rec_t;

  typedef struct packed {
    logic [NREC_W-1:0]         n;
    rec_t [MAX_RECS-1:0]       recs;
  } enc_out_t;

  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W:0] sum);
    logic [CNT_W-1:0] res;
    if (sum > (CNT_W+1)'(COUNT_MAX)) begin
      res = CNT_W'(COUNT_MAX);
    end else begin
      res = sum[CNT_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> design/clrle_encode.sv
// Run tracking, symbol histogram and record generation for one code length.
module clrle_encode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [3:0]            code_length,
  input  logic                  last_length,
  output clrle_pkg::enc_out_t   enc
);
  import clrle_pkg::*;

  logic                 run_active;
  logic [3:0]           run_value;
  logic [REP_W-1:0]     run_pending;
  logic [CNT_W-1:0]     hist [NUM_SYMS];
  logic [ITEM_W-1:0]    items_seen;

  logic                 act;
  logic [3:0]           val;
  logic [REP_W-1:0]     pend;
  logic [NREC_W-1:0]    n;
  logic [SYM_W-1:0]     sym [MAX_RECS];
  logic [REP_W-1:0]     rep [MAX_RECS];
  logic                 block_end;
  logic [CNT_W-1:0]     hist_next [NUM_SYMS];

  always_comb begin
    act = run_active;
    val = run_value;
    pend = run_pending;
    n = '0;
    for (int k = 0; k < MAX_RECS; k++) begin
      sym[k] = '0;
      rep[k] = '0;
    end
    block_end = last_length || (items_seen >= ITEM_W'(MAX_LENGTHS - 1));

    if (run_active && code_length == run_value) begin
      pend = run_pending + REP_W'(1);
      if (code_length == 4'd0) begin
        if (pend >= REP_W'(ZERO_CAP)) begin
          sym[n] = SYM_ZERO_LONG;
          rep[n] = REP_W'(ZERO_CAP);
          n = n + NREC_W'(1);
          pend = '0;
        end
      end else if (pend >= REP_W'(REP_CAP)) begin
        sym[n] = SYM_REP;
        rep[n] = REP_W'(REP_CAP);
        n = n + NREC_W'(1);
        pend = '0;
      end
    end else begin
      if (act) begin
        if (pend >= REP_W'(MIN_RUN)) begin
          if (val == 4'd0) begin
            sym[n] = (pend < REP_W'(ZERO_LONG_MIN)) ? SYM_ZERO_SHORT : SYM_ZERO_LONG;
          end else begin
            sym[n] = SYM_REP;
          end
          rep[n] = pend;
          n = n + NREC_W'(1);
        end else begin
          if (pend != '0) begin
            sym[n] = {1'b0, val};
            n = n + NREC_W'(1);
          end
          if (pend == REP_W'(2)) begin
            sym[n] = {1'b0, val};
            n = n + NREC_W'(1);
          end
        end
      end
      act = 1'b1;
      val = code_length;
      pend = (code_length == 4'd0) ? REP_W'(1) : '0;
      if (code_length != 4'd0) begin
        sym[n] = {1'b0, code_length};
        n = n + NREC_W'(1);
      end
    end

    if (block_end) begin
      if (pend >= REP_W'(MIN_RUN)) begin
        if (val == 4'd0) begin
          sym[n] = (pend < REP_W'(ZERO_LONG_MIN)) ? SYM_ZERO_SHORT : SYM_ZERO_LONG;
        end else begin
          sym[n] = SYM_REP;
        end
        rep[n] = pend;
        n = n + NREC_W'(1);
      end else begin
        if (pend != '0) begin
          sym[n] = {1'b0, val};
          n = n + NREC_W'(1);
        end
        if (pend == REP_W'(2)) begin
          sym[n] = {1'b0, val};
          n = n + NREC_W'(1);
        end
      end
    end
  end

  always_comb begin
    logic [NREC_W-1:0] hits;
    logic [NREC_W-1:0] inc;
    enc.n = n;
    for (int k = 0; k < MAX_RECS; k++) begin
      hits = '0;
      for (int j = 0; j <= k; j++) begin
        if (sym[j] == sym[k]) begin
          hits = hits + NREC_W'(1);
        end
      end
      enc.recs[k].sym = sym[k];
      enc.recs[k].rep = rep[k];
      enc.recs[k].cnt = sat_count({1'b0, hist[sym[k]]} + (CNT_W+1)'(hits));
      enc.recs[k].last_item = (NREC_W'(k + 1) == n);
      enc.recs[k].eob = block_end && (NREC_W'(k + 1) == n);
    end
    for (int i = 0; i < NUM_SYMS; i++) begin
      inc = '0;
      for (int k = 0; k < MAX_RECS; k++) begin
        if (NREC_W'(k) < n && sym[k] == SYM_W'(i)) begin
          inc = inc + NREC_W'(1);
        end
      end
      hist_next[i] = block_end ? '0 : sat_count({1'b0, hist[i]} + (CNT_W+1)'(inc));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      run_value <= '0;
      run_pending <= '0;
      items_seen <= '0;
      for (int i = 0; i < NUM_SYMS; i++) begin
        hist[i] <= '0;
      end
    end else if (go) begin
      run_active <= block_end ? 1'b0 : act;
      run_value <= block_end ? '0 : val;
      run_pending <= block_end ? '0 : pend;
      items_seen <= block_end ? '0 : items_seen + ITEM_W'(1);
      for (int i = 0; i < NUM_SYMS; i++) begin
        hist[i] <= hist_next[i];
      end
    end
  end

endmodule

>>> design/code_length_run_length_encoder.sv
// Code-length run-length encoder top level: input register, encoder, record queue.
// An item's records pass through the input register and then the record queue. Throughput: one
// item per cycle while items yield at most one record each and m_tready is high; records leave
// at one per cycle while m_tready is high, and every item waits until the five-entry record
// queue has room for three records. Reset clears the run state, histogram, item count and queue.
module code_length_run_length_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] code_length, [7:4] zero
  input  logic        s_tlast,   // last_length
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [4:0] code_symbol, [12:5] repeat_count, [22:13] symbol_count
  output logic        m_tuser,   // last_of_item
  output logic        m_tlast    // end_of_block
);
  import clrle_pkg::*;

  logic               stg_valid;
  logic [3:0]         stg_len;
  logic               stg_last;
  logic               stg_go;
  enc_out_t           enc;

  rec_t               q [QUEUE_DEPTH];
  rec_t               q_next [QUEUE_DEPTH];
  logic [QCNT_W-1:0]  qcount;
  logic [QCNT_W-1:0]  qcount_next;
  logic [QIDX_W-1:0]  base;
  logic               pop;

  assign stg_go   = stg_valid && (qcount <= QCNT_W'(QUEUE_DEPTH - MAX_RECS));
  assign s_tready = !stg_valid || stg_go;
  assign m_tvalid = (qcount != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {1'b0, q[0].cnt, q[0].rep, q[0].sym};
  assign m_tuser  = q[0].last_item;
  assign m_tlast  = q[0].eob;

  clrle_encode u_encode (
    .clk         (clk),
    .rst         (rst),
    .go          (stg_go),
    .code_length (stg_len),
    .last_length (stg_last),
    .enc         (enc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_tready) begin
      stg_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      stg_len <= s_tdata[3:0];
      stg_last <= s_tlast;
    end
  end

  always_comb begin
    base = QIDX_W'(qcount) - QIDX_W'(pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && i < QUEUE_DEPTH - 1) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
    end
    if (stg_go) begin
      for (int k = 0; k < MAX_RECS; k++) begin
        if (NREC_W'(k) < enc.n) begin
          q_next[base + QIDX_W'(k)] = enc.recs[k];
        end
      end
    end
    qcount_next = qcount - QCNT_W'(pop) + (stg_go ? QCNT_W'(enc.n) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qcount <= '0;
    end else begin
      qcount <= qcount_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  a_qcount_bound: assert property (@(posedge clk) disable iff (rst)
    qcount <= QCNT_W'(QUEUE_DEPTH))
    else $error("record queue overfilled");

  a_last_item_yields: assert property (@(posedge clk) disable iff (rst)
    stg_go && stg_last |-> enc.n != '0)
    else $error("final item of a block produced no record");

  a_eob_is_item_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("end of block without end of item");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    qcount == '0 |-> s_tready)
    else $error("input stalled with an empty record queue");

endmodule

>>> tb/tb.sv
// Self-checking stream testbench for the code-length run-length encoder.
`timescale 1ns / 100ps

module tb;
  import clrle_pkg::*;

  class rle_record_tracker;
    bit          run_open;
    logic [3:0]  run_level;
    int unsigned run_held;
    int unsigned block_len;
    int unsigned tally [NUM_SYMS];
    rec_t        step_recs [$];
    rec_t        due_records [$];
    int          errors;
    int          records_seen;
    int          blocks_seen;

    function new();
      errors = 0;
      records_seen = 0;
      blocks_seen = 0;
      clear_block();
    endfunction

    function void clear_block();
      run_open = 1'b0;
      run_level = 4'd0;
      run_held = 0;
      block_len = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function void add_record(int unsigned sym, int unsigned rep);
      rec_t r;
      if (tally[sym] < COUNT_MAX) tally[sym]++;
      r.sym = SYM_W'(sym);
      r.rep = REP_W'(rep);
      r.cnt = CNT_W'(tally[sym]);
      r.last_item = 1'b0;
      r.eob = 1'b0;
      step_recs = {step_recs, r};
    endfunction

    function void close_run();
      if (!run_open) return;
      if (run_held >= MIN_RUN) begin
        if (run_level == 4'd0) begin
          add_record(32'(run_held < ZERO_LONG_MIN ? SYM_ZERO_SHORT : SYM_ZERO_LONG), run_held);
        end else begin
          add_record(32'(SYM_REP), run_held);
        end
      end else begin
        for (int i = 0; i < run_held; i++) add_record(32'(run_level), 0);
      end
      run_held = 0;
    endfunction

    // predict the records caused by one accepted code length
    function void encode_length(logic [3:0] len, logic lst);
      bit          closes;
      int unsigned cap;
      rec_t        tail;
      closes = lst || (block_len + 1 >= MAX_LENGTHS);
      step_recs.delete();
      if (run_open && len == run_level) begin
        cap = (len == 4'd0) ? ZERO_CAP : REP_CAP;
        run_held++;
        if (run_held >= cap) begin
          add_record(32'(len == 4'd0 ? SYM_ZERO_LONG : SYM_REP), cap);
          run_held = 0;
        end
      end else begin
        close_run();
        run_open = 1'b1;
        run_level = len;
        if (len == 4'd0) begin
          run_held = 1;
        end else begin
          add_record(32'(len), 0);
          run_held = 0;
        end
      end
      if (closes) begin
        close_run();
        blocks_seen++;
      end
      if (step_recs.size() > 0) begin
        tail = step_recs[step_recs.size() - 1];
        tail.last_item = 1'b1;
        tail.eob = closes;
        step_recs[step_recs.size() - 1] = tail;
      end
      if (closes) begin
        clear_block();
      end else begin
        block_len++;
      end
      foreach (step_recs[i]) due_records = {due_records, step_recs[i]};
    endfunction

    function void compare_field(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      end
    endfunction

    function void check_record(logic [SYM_W-1:0] sym, logic [REP_W-1:0] rep,
                               logic [CNT_W-1:0] cnt, logic item_end, logic blk_end);
      rec_t want;
      if (due_records.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none, actual sym %0d rep %0d count %0d",
                 $time, sym, rep, cnt);
        return;
      end
      want = due_records.pop_front();
      records_seen++;
      compare_field("code_symbol", 32'(want.sym), 32'(sym));
      compare_field("repeat_count", 32'(want.rep), 32'(rep));
      compare_field("symbol_count", 32'(want.cnt), 32'(cnt));
      compare_field("last_of_item", 32'(want.last_item), 32'(item_end));
      compare_field("end_of_block", 32'(want.eob), 32'(blk_end));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [23:0] m_tdata;
  wire         m_tuser;
  wire         m_tlast;

  rle_record_tracker tracker = new();
  bit steady = 1'b0;
  int items_sent = 0;

  code_length_run_length_encoder uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_record(m_tdata[4:0], m_tdata[12:5], m_tdata[22:13], m_tuser, m_tlast);
    end
  end

  task automatic send_length(input logic [3:0] len, input logic lst);
    while (!steady && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0000, len};
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.encode_length(len, lst);
    items_sent++;
  endtask

  task automatic send_run(input logic [3:0] len, input int count, input bit close);
    for (int i = 0; i < count; i++) send_length(len, close && (i == count - 1));
  endtask

  function automatic int pick_run_len();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: n = $urandom_range(1, 3);
      5, 6, 7: n = $urandom_range(4, 8);
      8: n = $urandom_range(9, 14);
      default: n = $urandom_range(15, 30);
    endcase
    return n;
  endfunction

  function automatic logic [3:0] pick_level();
    logic [3:0] lvl;
    lvl = ($urandom_range(0, 9) < 4) ? 4'd0 : 4'($urandom_range(1, 15));
    return lvl;
  endfunction

  task automatic send_random_block(input int n_runs, input bit close);
    for (int r = 0; r < n_runs; r++) begin
      send_run(pick_level(), pick_run_len(), close && (r == n_runs - 1));
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_length(4'($urandom_range(0, 15)), (i == n - 1) && ($urandom_range(0, 1) == 1));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_run(4'd0, 1, 1'b1);
    send_run(4'd15, 4, 1'b1);
    send_run(4'd0, 3, 1'b1);
    send_run(4'd7, 7, 1'b0);
    send_run(4'd0, 2, 1'b1);
    send_run(4'd5, 3, 1'b0);
    send_run(4'd3, 1, 1'b1);
    send_run(4'd0, 2, 1'b0);
    send_run(4'd1, 1, 1'b1);

    steady <= 1'b1;
    send_run(4'd0, 10, 1'b1);
    send_run(4'd0, 11, 1'b1);
    send_run(4'd9, 13, 1'b1);
    steady <= 1'b0;

    while (items_sent < 85) begin
      if ($urandom_range(0, 4) == 0) begin
        send_noise($urandom_range(4, 10));
      end else begin
        send_random_block($urandom_range(1, 4), 1'b1);
      end
    end
    send_length(4'($urandom_range(0, 15)), 1'b1);
    s_tvalid <= 1'b0;

    while (tracker.due_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d code lengths in %0d blocks, checked %0d records",
             items_sent, tracker.blocks_seen, tracker.records_seen);
    $display("Covered literal, repeat and zero-run records, the short/long zero-run split, "
             , "repeat caps and stalls on both sides");
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: run timed out", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> code_length_run_length_encoder.f
design/clrle_pkg.sv
design/clrle_encode.sv
design/code_length_run_length_encoder.sv
tb/tb.sv
